### rtl/gcbt_pkg.sv
// Shared types and constants for the greedy climb budget tracker.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package gcbt_pkg;

   // Field widths
   localparam int HEIGHT_W  = 20;
   localparam int INDEX_W   = 16;
   localparam int ENERGY_W  = 30;
   localparam int ROPE_W    = 6;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = ENERGY_W;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENERGY_BUDGET = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROPE_COUNT    = 1'd1;

   // Command from the item control to the heap sequencer
   typedef struct packed {
      logic                clear;
      logic                go;
      logic [HEIGHT_W-1:0] climb;
      logic [ROPE_W-1:0]   ropes;
   } heap_op_type;

   // Completion report from the heap sequencer
   typedef struct packed {
      logic                done;
      logic                popped;
      logic [HEIGHT_W-1:0] cost;
   } heap_res_type;

   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_WAIT,
      TOP_FINISH
   } top_state_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_PUSH_RD,
      SEQ_PUSH_CMP,
      SEQ_DECIDE,
      SEQ_POP_TOP,
      SEQ_POP_RD,
      SEQ_POP_CMP
   } seq_state_type;

endpackage

`default_nettype wire

### rtl/gcbt_req_if.sv
// Input channel of the tracker: valid/ready handshake with height and start flag.
// Depends on gcbt_pkg for field widths.
`default_nettype none

interface gcbt_req_if;
   import gcbt_pkg::*;

   logic                valid;
   logic                ready;
   logic [HEIGHT_W-1:0] height;
   logic                start_req;

   modport source (output valid, output height, output start_req, input ready);
   modport sink   (input valid, input height, input start_req, output ready);
endinterface

`default_nettype wire

### rtl/gcbt_rsp_if.sv
// Result channel of the tracker: valid/ready handshake with reach index and blocked flag.
// Depends on gcbt_pkg for field widths.
`default_nettype none

interface gcbt_rsp_if;
   import gcbt_pkg::*;

   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] reach_index;
   logic               blocked;

   modport source (output valid, output reach_index, output blocked, input ready);
   modport sink   (input valid, input reach_index, input blocked, output ready);
endinterface

`default_nettype wire

### rtl/gcbt_heap_ram.sv
// Climb heap storage: one write port, two read ports with registered read data.
// Depends on gcbt_pkg for the entry width.
`default_nettype none

module gcbt_heap_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire                            clock,
   input  wire                            wr_en,
   input  wire  [AW-1:0]                  wr_addr,
   input  wire  [gcbt_pkg::HEIGHT_W-1:0]  wr_data,
   input  wire  [AW-1:0]                  rd_addr_a,
   input  wire  [AW-1:0]                  rd_addr_b,
   output logic [gcbt_pkg::HEIGHT_W-1:0]  rd_data_a,
   output logic [gcbt_pkg::HEIGHT_W-1:0]  rd_data_b
);
   import gcbt_pkg::*;

   logic [HEIGHT_W-1:0] mem [DEPTH];

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read two entries, registered
   always_ff @(posedge clock) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

`default_nettype wire

### rtl/gcbt_heap_seq.sv
// Heap sequencer: sifts one level at a time, through a read state and a compare state, for insert and for pop,
// reusing one compare path; owns the fill count. Depends on gcbt_pkg, gcbt_heap_ram.
`default_nettype none

module gcbt_heap_seq #(
   parameter int HEAP_DEPTH = 64
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire gcbt_pkg::heap_op_type op,
   output gcbt_pkg::heap_res_type  res
);
   import gcbt_pkg::*;

   localparam int AW = $clog2(HEAP_DEPTH);
   localparam int CW = AW + 1;
   localparam int RW = (CW > ROPE_W) ? CW : ROPE_W;

   seq_state_type       state_ff, state_in;
   logic [CW-1:0]       fill_ff, fill_in;
   logic [AW-1:0]       pos_ff, pos_in;
   logic [HEIGHT_W-1:0] val_ff, val_in;
   logic [HEIGHT_W-1:0] top_ff, top_in;
   logic [ROPE_W-1:0]   ropes_ff, ropes_in;
   logic                done_ff, done_in;
   logic                popped_ff, popped_in;
   logic [HEIGHT_W-1:0] cost_ff, cost_in;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [HEIGHT_W-1:0] wr_data;
   logic [AW-1:0]       rd_addr_a;
   logic [AW-1:0]       rd_addr_b;
   logic [HEIGHT_W-1:0] rd_data_a;
   logic [HEIGHT_W-1:0] rd_data_b;

   logic [AW-1:0]       parent;
   logic [CW-1:0]       child_l;
   logic [CW-1:0]       child_r;
   logic [CW-1:0]       fill_dec;
   logic                right_ok;
   logic                pick_right;
   logic [HEIGHT_W-1:0] cmp_a;
   logic [HEIGHT_W-1:0] cmp_b;
   logic                cmp_le;
   logic [RW-1:0]       ropes_lim;
   logic [RW-1:0]       ropes_ext;

   gcbt_heap_ram #(
      .DEPTH (HEAP_DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // Tree navigation
   assign parent     = AW'((pos_ff - 1'b1) >> 1);
   assign child_l    = {pos_ff, 1'b1};
   assign child_r    = child_l + 1'b1;
   assign fill_dec   = fill_ff - 1'b1;
   assign right_ok   = child_r < fill_ff;
   assign pick_right = right_ok && (rd_data_b < rd_data_a);

   // Clamp the rope count to one less than the heap depth
   assign ropes_ext = RW'(ropes_ff);
   assign ropes_lim = (ropes_ext > RW'(HEAP_DEPTH - 1)) ? RW'(HEAP_DEPTH - 1) : ropes_ext;

   // Shared compare: moving value against parent or smaller child
   always_comb begin
      cmp_a = val_ff;
      cmp_b = rd_data_a;
      if (state_ff == SEQ_POP_CMP && pick_right) begin
         cmp_b = rd_data_b;
      end
   end
   assign cmp_le = (state_ff == SEQ_PUSH_CMP) ? (cmp_b <= cmp_a) : (cmp_a <= cmp_b);

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= SEQ_IDLE;
         fill_ff   <= '0;
         done_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         done_ff   <= done_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      top_ff    <= top_in;
      ropes_ff  <= ropes_in;
      popped_ff <= popped_in;
      cost_ff   <= cost_in;
   end

   // Next state, memory control
   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      top_in    = top_ff;
      ropes_in  = ropes_ff;
      done_in   = 1'b0;
      popped_in = popped_ff;
      cost_in   = cost_ff;
      wr_en     = 1'b0;
      wr_addr   = pos_ff;
      wr_data   = val_ff;
      rd_addr_a = parent;
      rd_addr_b = parent;

      case (state_ff)
         SEQ_IDLE: begin
            if (op.clear) begin
               fill_in = '0;
            end else if (op.go) begin
               ropes_in = op.ropes;
               val_in   = op.climb;
               if (fill_ff == CW'(HEAP_DEPTH)) begin
                  state_in = SEQ_DECIDE;
               end else begin
                  pos_in   = fill_ff[AW-1:0];
                  fill_in  = fill_ff + 1'b1;
                  state_in = SEQ_PUSH_RD;
               end
            end
         end

         // Insert: fetch the parent or settle at the root
         SEQ_PUSH_RD: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               state_in = SEQ_DECIDE;
            end else begin
               state_in = SEQ_PUSH_CMP;
            end
         end

         // Insert: stop under a parent no larger, else move the parent down
         SEQ_PUSH_CMP: begin
            wr_en = 1'b1;
            if (cmp_le) begin
               state_in = SEQ_DECIDE;
            end else begin
               wr_data  = rd_data_a;
               pos_in   = parent;
               state_in = SEQ_PUSH_RD;
            end
         end

         // Pop the smallest climb once ropes run short
         SEQ_DECIDE: begin
            if (RW'(fill_ff) > ropes_lim) begin
               fill_in   = fill_dec;
               rd_addr_a = '0;
               rd_addr_b = fill_dec[AW-1:0];
               state_in  = SEQ_POP_TOP;
            end else begin
               done_in   = 1'b1;
               popped_in = 1'b0;
               state_in  = SEQ_IDLE;
            end
         end

         // Pop: hold the root as cost, take the last entry as the mover
         SEQ_POP_TOP: begin
            top_in = rd_data_a;
            val_in = rd_data_b;
            pos_in = '0;
            if (fill_ff == '0) begin
               done_in   = 1'b1;
               popped_in = 1'b1;
               cost_in   = rd_data_a;
               state_in  = SEQ_IDLE;
            end else begin
               state_in = SEQ_POP_RD;
            end
         end

         // Pop: fetch both children or settle at a leaf
         SEQ_POP_RD: begin
            rd_addr_a = child_l[AW-1:0];
            rd_addr_b = child_r[AW-1:0];
            if (child_l >= fill_ff) begin
               wr_en     = 1'b1;
               done_in   = 1'b1;
               popped_in = 1'b1;
               cost_in   = top_ff;
               state_in  = SEQ_IDLE;
            end else begin
               state_in = SEQ_POP_CMP;
            end
         end

         // Pop: stop above a child no smaller, else lift the smaller child
         SEQ_POP_CMP: begin
            wr_en = 1'b1;
            if (cmp_le) begin
               done_in   = 1'b1;
               popped_in = 1'b1;
               cost_in   = top_ff;
               state_in  = SEQ_IDLE;
            end else begin
               wr_data  = cmp_b;
               pos_in   = pick_right ? child_r[AW-1:0] : child_l[AW-1:0];
               state_in = SEQ_POP_RD;
            end
         end

         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   assign res.done   = done_ff;
   assign res.popped = popped_ff;
   assign res.cost   = cost_ff;

endmodule

`default_nettype wire

### rtl/greedy_climb_budget_tracker.sv
// Top level of the greedy climb budget tracker: handshakes, configuration,
// energy and reach tracking. Depends on gcbt_pkg, gcbt_req_if, gcbt_rsp_if, gcbt_heap_seq.
//
//   Channel  Direction  Transfer when      Carries
//   req_ch   in         valid & ready      height, start_req
//   rsp_ch   out        valid & ready      reach_index, blocked
//   csr_*    in         csr_wr_en          csr_index, csr_wr_data
//
// A start, a blocked item or a non-rising item passes from idle straight to the finish
// state. A rise also waits on one heap insert (a read and a compare state per level
// climbed) and, when ropes run short, one pop (a read and a compare state per level
// descended). The single heap sequencer and its two-read-port memory set how long a rise takes.
// Reset is synchronous; the heap needs no clearing pass after reset.
// A result waits in the output register; the next item is taken once it is loaded.
`default_nettype none

module greedy_climb_budget_tracker #(
   parameter int HEAP_DEPTH = 64
) (
   input  wire                              clock,
   input  wire                              reset,
   gcbt_req_if.sink                         req_ch,
   gcbt_rsp_if.source                       rsp_ch,
   input  wire                              csr_wr_en,
   input  wire  [gcbt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [gcbt_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import gcbt_pkg::*;

   top_state_type       state_ff, state_in;
   logic [ENERGY_W-1:0] budget_ff;
   logic [ROPE_W-1:0]   ropes_ff;
   logic [HEIGHT_W-1:0] prev_height_ff, prev_height_in;
   logic [ENERGY_W-1:0] energy_ff, energy_in;
   logic [INDEX_W-1:0]  index_ff, index_in;
   logic                stuck_ff, stuck_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic                rsp_blocked_ff, rsp_blocked_in;

   logic                accept;
   logic                rise;
   logic [INDEX_W-1:0]  index_inc;
   heap_op_type         op;
   heap_res_type        res;

   gcbt_heap_seq #(
      .HEAP_DEPTH (HEAP_DEPTH)
   ) u_seq (
      .clock (clock),
      .reset (reset),
      .op    (op),
      .res   (res)
   );

   assign req_ch.ready = (state_ff == TOP_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign rise         = req_ch.height > prev_height_ff;
   assign index_inc    = (index_ff == '1) ? index_ff : index_ff + 1'b1;

   // Heap command for this transfer
   always_comb begin
      op.clear = accept && req_ch.start_req;
      op.go    = accept && !req_ch.start_req && !stuck_ff && rise;
      op.climb = req_ch.height - prev_height_ff;
      op.ropes = ropes_ff;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= '0;
         ropes_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ENERGY_BUDGET: budget_ff <= csr_wr_data;
            CSR_ROPE_COUNT:    ropes_ff  <= csr_wr_data[ROPE_W-1:0];
            default:           ;
         endcase
      end
   end

   // Control and tracking state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= TOP_IDLE;
         prev_height_ff <= '0;
         energy_ff      <= '0;
         index_ff       <= '0;
         stuck_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         prev_height_ff <= prev_height_in;
         energy_ff      <= energy_in;
         index_ff       <= index_in;
         stuck_ff       <= stuck_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Output payload
   always_ff @(posedge clock) begin
      rsp_index_ff   <= rsp_index_in;
      rsp_blocked_ff <= rsp_blocked_in;
   end

   // Next state
   always_comb begin
      state_in       = state_ff;
      prev_height_in = prev_height_ff;
      energy_in      = energy_ff;
      index_in       = index_ff;
      stuck_in       = stuck_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_index_in   = rsp_index_ff;
      rsp_blocked_in = rsp_blocked_ff;

      case (state_ff)
         TOP_IDLE: begin
            if (accept) begin
               state_in = TOP_FINISH;
               if (req_ch.start_req) begin
                  prev_height_in = req_ch.height;
                  energy_in      = budget_ff;
                  index_in       = '0;
                  stuck_in       = 1'b0;
               end else if (!stuck_ff) begin
                  prev_height_in = req_ch.height;
                  if (rise) begin
                     state_in = TOP_WAIT;
                  end else begin
                     index_in = index_inc;
                  end
               end
            end
         end

         // Pay the popped climb or latch blocked
         TOP_WAIT: begin
            if (res.done) begin
               state_in = TOP_FINISH;
               if (res.popped && (ENERGY_W'(res.cost) > energy_ff)) begin
                  stuck_in = 1'b1;
               end else begin
                  if (res.popped) begin
                     energy_in = energy_ff - ENERGY_W'(res.cost);
                  end
                  index_in = index_inc;
               end
            end
         end

         // Load the output register once it is free
         TOP_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_index_in   = index_ff;
               rsp_blocked_in = stuck_ff;
               state_in       = TOP_IDLE;
            end
         end

         default: begin
            state_in = TOP_IDLE;
         end
      endcase
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.reach_index = rsp_index_ff;
   assign rsp_ch.blocked     = rsp_blocked_ff;

endmodule

`default_nettype wire
